>>> rtl/core/pcdg_pkg.sv
// Shared types and constants of the point cloud depth grid.
package pcdg_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int SIZE_W      = 9;
    localparam int READ_W      = 8;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SIZE_W-1:0] RESET_GRID_SIZE  = 9'd256;
    localparam logic [DATA_W-1:0] RESET_SPACING    = 32'h0001_0000;
    localparam logic [DATA_W-1:0] RESET_FILL_DEPTH = 32'hFC18_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS        = 3'd0,
        CFG_GRID_ROWS           = 3'd1,
        CFG_CELL_WIDTH          = 3'd2,
        CFG_CELL_HEIGHT         = 3'd3,
        CFG_INVERSE_CELL_WIDTH  = 3'd4,
        CFG_INVERSE_CELL_HEIGHT = 3'd5,
        CFG_FILL_DEPTH          = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic [READ_W-1:0]        read_column;
        logic [READ_W-1:0]        read_row;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] cell_x;
        logic signed [DATA_W-1:0] cell_y;
        logic signed [DATA_W-1:0] cell_depth;
        logic                     out_of_grid;
    } t_rsp;

    // Configuration as the datapath sees it, grid sizes already clamped.
    typedef struct packed {
        logic [SIZE_W-1:0] columns;
        logic [SIZE_W-1:0] rows;
        logic [COL_W-1:0]  half_columns;
        logic [ROW_W-1:0]  half_rows;
        logic [DATA_W-1:0] cell_width;
        logic [DATA_W-1:0] cell_height;
        logic [DATA_W-1:0] inverse_cell_width;
        logic [DATA_W-1:0] inverse_cell_height;
        logic [DATA_W-1:0] fill_depth;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_POINT_X = 2'd0,
        MUL_POINT_Y = 2'd1,
        MUL_CELL_X  = 2'd2,
        MUL_CELL_Y  = 2'd3
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_SWEEP  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_ADD_X  = 3'd2,
        ST_ADD_Y  = 3'd3,
        ST_ADD_WR = 3'd4,
        ST_RD_X   = 3'd5,
        ST_RD_Y   = 3'd6,
        ST_RD_OUT = 3'd7
    } t_state;

    typedef struct packed {
        logic     load_req;
        logic     sweep_start;
        logic     sweep_en;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     take_col;
        logic     store_add;
        logic     mem_rd;
        logic     take_cell_x;
        logic     load_rsp;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic rsp_free;
    } t_dp_stat;

endpackage

>>> rtl/core/pcdg_cfg.sv
// Configuration registers with grid size clamping.
module pcdg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcdg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcdg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pcdg_pkg::t_cfg                 o_cfg
);
    import pcdg_pkg::*;

    logic [SIZE_W-1:0] r_grid_columns;
    logic [SIZE_W-1:0] r_grid_rows;
    logic [DATA_W-1:0] r_cell_width;
    logic [DATA_W-1:0] r_cell_height;
    logic [DATA_W-1:0] r_inverse_cell_width;
    logic [DATA_W-1:0] r_inverse_cell_height;
    logic [DATA_W-1:0] r_fill_depth;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns        <= RESET_GRID_SIZE;
            r_grid_rows           <= RESET_GRID_SIZE;
            r_cell_width          <= RESET_SPACING;
            r_cell_height         <= RESET_SPACING;
            r_inverse_cell_width  <= RESET_SPACING;
            r_inverse_cell_height <= RESET_SPACING;
            r_fill_depth          <= RESET_FILL_DEPTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_COLUMNS:        r_grid_columns        <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_ROWS:           r_grid_rows           <= i_cfg_data[SIZE_W-1:0];
                CFG_CELL_WIDTH:          r_cell_width          <= i_cfg_data[DATA_W-1:0];
                CFG_CELL_HEIGHT:         r_cell_height         <= i_cfg_data[DATA_W-1:0];
                CFG_INVERSE_CELL_WIDTH:  r_inverse_cell_width  <= i_cfg_data[DATA_W-1:0];
                CFG_INVERSE_CELL_HEIGHT: r_inverse_cell_height <= i_cfg_data[DATA_W-1:0];
                CFG_FILL_DEPTH:          r_fill_depth          <= i_cfg_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_columns == '0) begin
            cols = SIZE_W'(1);
        end else if (r_grid_columns > SIZE_W'(MAX_COLUMNS)) begin
            cols = SIZE_W'(MAX_COLUMNS);
        end else begin
            cols = r_grid_columns;
        end
        if (r_grid_rows == '0) begin
            rows = SIZE_W'(1);
        end else if (r_grid_rows > SIZE_W'(MAX_ROWS)) begin
            rows = SIZE_W'(MAX_ROWS);
        end else begin
            rows = r_grid_rows;
        end
    end

    always_comb begin
        o_cfg.columns             = cols;
        o_cfg.rows                = rows;
        o_cfg.half_columns        = cols[SIZE_W-1:1];
        o_cfg.half_rows           = rows[SIZE_W-1:1];
        o_cfg.cell_width          = r_cell_width;
        o_cfg.cell_height         = r_cell_height;
        o_cfg.inverse_cell_width  = r_inverse_cell_width;
        o_cfg.inverse_cell_height = r_inverse_cell_height;
        o_cfg.fill_depth          = r_fill_depth;
    end

endmodule

>>> rtl/core/pcdg_ctrl.sv
// Controller state machine: sequences sweeps, adds and reads.
module pcdg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic [1:0]         i_action,
    input  pcdg_pkg::t_dp_stat i_stat,
    output logic               o_req_ready,
    output pcdg_pkg::t_dp_cmd  o_cmd
);
    import pcdg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_POINT_X;
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = ST_SWEEP;
                        end
                        ACT_ADD:  n_state = ST_ADD_X;
                        ACT_READ: n_state = ST_RD_X;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_POINT_X;
                n_state       = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                o_cmd.take_col = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_POINT_Y;
                n_state        = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                o_cmd.store_add = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_RD_X: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CELL_X;
                n_state       = ST_RD_Y;
            end
            ST_RD_Y: begin
                o_cmd.take_cell_x = 1'b1;
                o_cmd.mul_en      = 1'b1;
                o_cmd.mul_sel     = MUL_CELL_Y;
                n_state           = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                // wait here while the previous response is still held
                if (i_stat.rsp_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/pcdg_dp.sv
// Datapath: shared multiplier, index math, depth store and response register.
module pcdg_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcdg_pkg::t_cfg     i_cfg,
    input  pcdg_pkg::t_req     i_req,
    input  pcdg_pkg::t_dp_cmd  i_cmd,
    output pcdg_pkg::t_dp_stat o_stat,
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    output pcdg_pkg::t_rsp     o_rsp
);
    import pcdg_pkg::*;

    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam int DIFF_W      = SIZE_W + 1;
    localparam int MAG_W       = PROD_W - DATA_W + 8;

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    t_req              r_req;
    logic [DATA_W-1:0] r_mag_x;
    logic [DATA_W-1:0] r_mag_y;
    logic              r_neg_x;
    logic              r_neg_y;
    logic [PROD_W-1:0] r_prod;
    logic [COL_W-1:0]  r_col;
    logic              r_col_ok;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_cell_x;
    logic [ADDR_W-1:0] r_sweep_addr;
    logic [DATA_W-1:0] r_sweep_value;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] q;
    logic [COL_W-1:0]  col_idx;
    logic              col_ok;
    logic [ROW_W-1:0]  row_idx;
    logic              row_ok;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [SIZE_W-1:0] dx_mag;
    logic [SIZE_W-1:0] dy_mag;
    logic              out_of_grid;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    // (2*index - size) * spacing / 2, truncated toward zero and saturated
    function automatic logic [DATA_W-1:0] centered(input logic neg,
                                                   input logic [PROD_W-1:0] prod);
        logic [MAG_W-1:0] mag;
        mag = prod[MAG_W:1];
        if (neg) begin
            centered = (mag > MAG_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                           : DATA_W'(-mag);
        end else begin
            centered = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
        end
    endfunction

    assign q = r_prod[PROD_W-1:DATA_W];

    always_comb begin
        // a negative coordinate lands at half - q, a positive one at half + q
        if (r_neg_x) begin
            col_ok  = q <= DATA_W'(i_cfg.half_columns);
            col_idx = i_cfg.half_columns - q[COL_W-1:0];
        end else begin
            col_ok  = q < DATA_W'(i_cfg.columns - SIZE_W'(i_cfg.half_columns));
            col_idx = i_cfg.half_columns + q[COL_W-1:0];
        end
        if (r_neg_y) begin
            row_ok  = q <= DATA_W'(i_cfg.half_rows);
            row_idx = i_cfg.half_rows - q[ROW_W-1:0];
        end else begin
            row_ok  = q < DATA_W'(i_cfg.rows - SIZE_W'(i_cfg.half_rows));
            row_idx = i_cfg.half_rows + q[ROW_W-1:0];
        end
    end

    always_comb begin
        dx     = {1'b0, r_req.read_column, 1'b0} - {1'b0, i_cfg.columns};
        dy     = {1'b0, r_req.read_row, 1'b0} - {1'b0, i_cfg.rows};
        dx_mag = dx[DIFF_W-1] ? SIZE_W'(-dx) : dx[SIZE_W-1:0];
        dy_mag = dy[DIFF_W-1] ? SIZE_W'(-dy) : dy[SIZE_W-1:0];
        out_of_grid = ({1'b0, r_req.read_column} >= i_cfg.columns)
                   || ({1'b0, r_req.read_row} >= i_cfg.rows);
        rd_addr = {r_req.read_row[ROW_W-1:0], r_req.read_column[COL_W-1:0]};
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_POINT_X: begin
                mul_a = r_mag_x;
                mul_b = i_cfg.inverse_cell_width;
            end
            MUL_POINT_Y: begin
                mul_a = r_mag_y;
                mul_b = i_cfg.inverse_cell_height;
            end
            MUL_CELL_X: begin
                mul_a = DATA_W'(dx_mag);
                mul_b = i_cfg.cell_width;
            end
            MUL_CELL_Y: begin
                mul_a = DATA_W'(dy_mag);
                mul_b = i_cfg.cell_height;
            end
            default: begin
                mul_a = r_mag_x;
                mul_b = i_cfg.inverse_cell_width;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_req;
            r_neg_x <= i_req.point_x[DATA_W-1];
            r_neg_y <= i_req.point_y[DATA_W-1];
            r_mag_x <= i_req.point_x[DATA_W-1] ? DATA_W'(-i_req.point_x) : i_req.point_x;
            r_mag_y <= i_req.point_y[DATA_W-1] ? DATA_W'(-i_req.point_y) : i_req.point_y;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.take_col) begin
            r_col    <= col_idx;
            r_col_ok <= col_ok;
        end
        if (i_cmd.take_cell_x) begin
            r_cell_x <= centered(dx[DIFF_W-1], r_prod);
        end
    end

    // clear sweep: one store entry per cycle with the value latched at its start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr  <= '0;
            r_sweep_value <= RESET_FILL_DEPTH;
        end else if (i_cmd.sweep_start) begin
            r_sweep_addr  <= '0;
            r_sweep_value <= i_cfg.fill_depth;
        end else if (i_cmd.sweep_en) begin
            r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
        end
    end

    always_comb begin
        if (i_cmd.sweep_en) begin
            mem_we  = 1'b1;
            wr_addr = r_sweep_addr;
            wr_data = r_sweep_value;
        end else begin
            mem_we  = i_cmd.store_add && r_col_ok && row_ok;
            wr_addr = {row_idx, r_col};
            wr_data = r_req.point_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.load_rsp) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            if (out_of_grid) begin
                r_rsp <= '{cell_x: '0, cell_y: '0, cell_depth: '0, out_of_grid: 1'b1};
            end else begin
                r_rsp.cell_x      <= r_cell_x;
                r_rsp.cell_y      <= centered(dy[DIFF_W-1], r_prod);
                r_rsp.cell_depth  <= r_rd_data;
                r_rsp.out_of_grid <= 1'b0;
            end
        end
    end

    assign o_stat.sweep_last = r_sweep_addr == '1;
    assign o_stat.rsp_free   = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid       = r_rsp_valid;
    assign o_rsp             = r_rsp;

endmodule

>>> rtl/core/point_cloud_depth_grid.sv
// Point cloud depth grid: splats points onto a 2D depth store and reads cells back.
//
// Request channel (i_req_valid / o_req_ready, payload i_req) carries clear, add
// and read requests; response channel (o_rsp_valid / i_rsp_ready, payload o_rsp)
// returns one item per read request, none for clear or add.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data, one per cycle.
// Add and read are not overlapped: a new request is taken only once the last
// one is done, as one shared 32x32 multiplier is used twice per request, plus
// the registered store read/write. Reads go RD_X, RD_Y, RD_OUT; the last loads o_rsp.
// Clear: a sweep writes the latched fill depth into all 65536 store entries,
// one per cycle; requests are held off until the sweep ends.
// Reset: synchronous, active low; afterwards the same sweep runs with the reset
// fill depth before the first request is taken. Configuration writes are taken
// during the sweep.
// Stall: the response sits in an output register; a read that finishes while it
// is still held waits, as do requests behind it; add and clear go on otherwise.
module point_cloud_depth_grid (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  pcdg_pkg::t_req                  i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output pcdg_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [pcdg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcdg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcdg_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    pcdg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_action    (i_req.action),
        .i_stat      (stat),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd)
    );

    pcdg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

>>> tb/point_cloud_depth_grid_tb.sv
// Self-checking testbench for the point cloud depth grid: directed and random requests, scoreboarded reads.
module point_cloud_depth_grid_tb;
    import pcdg_pkg::*;

    localparam int          STORE_CELLS    = MAX_COLUMNS * MAX_ROWS;
    localparam int          SWEEP_CYCLES   = STORE_CELLS + 64;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          CYCLE_LIMIT    = 4_000_000;
    localparam int          PRESSURE_PHASE = 3;
    localparam int          HOLD_CYCLES    = SWEEP_CYCLES + 600;
    localparam int          RECENT_CELLS   = 16;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req       = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register shadow used by the predictor
    logic [SIZE_W-1:0] m_grid_columns;
    logic [SIZE_W-1:0] m_grid_rows;
    logic [DATA_W-1:0] m_cell_width;
    logic [DATA_W-1:0] m_cell_height;
    logic [DATA_W-1:0] m_inv_cell_width;
    logic [DATA_W-1:0] m_inv_cell_height;
    logic [DATA_W-1:0] m_fill_depth;

    logic [DATA_W-1:0] grid_depths [STORE_CELLS];
    t_rsp              pending_reads [$];
    t_req              req_backlog [$];

    int  sent_total     = 0;
    int  taken_total    = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  rsp_idle_pct   = 0;
    int  phase_id       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  req_fire       = 1'b0;
    bit  last_was_clear = 1'b0;

    point_cloud_depth_grid DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int grid_extent(logic [SIZE_W-1:0] reg_val, int limit);
        if (reg_val == 0) return 1;
        if (reg_val > limit) return limit;
        return reg_val;
    endfunction

    // trunc(coord * inverse) toward zero, sign applied after truncation
    function automatic longint scaled_index(logic signed [DATA_W-1:0] coord,
                                            logic [DATA_W-1:0] inv);
        longint      c;
        logic [63:0] mag;
        logic [63:0] q;
        c   = coord;
        mag = (c < 0) ? -c : c;
        q   = (mag * {32'd0, inv}) >> 32;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    // (2*idx - size) * spacing / 2, truncated toward zero, saturated to 32 bits
    function automatic logic [DATA_W-1:0] centered_coord(int idx, int size,
                                                         logic [DATA_W-1:0] spacing);
        longint      d2;
        logic [63:0] mag;
        d2  = 2 * longint'(idx) - longint'(size);
        mag = 64'((d2 < 0) ? -d2 : d2) * {32'd0, spacing} / 64'd2;
        if (d2 < 0) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    task automatic predict_grid_request(t_req r);
        int     cols;
        int     rows;
        longint col;
        longint row;
        t_rsp   rsp;
        cols = grid_extent(m_grid_columns, MAX_COLUMNS);
        rows = grid_extent(m_grid_rows, MAX_ROWS);
        case (r.action)
            ACT_CLEAR: begin
                for (int i = 0; i < STORE_CELLS; i++) grid_depths[i] = m_fill_depth;
            end
            ACT_ADD: begin
                col = scaled_index(r.point_x, m_inv_cell_width) + cols / 2;
                row = scaled_index(r.point_y, m_inv_cell_height) + rows / 2;
                if (col >= 0 && col < cols && row >= 0 && row < rows)
                    grid_depths[row * MAX_COLUMNS + col] = r.point_z;
            end
            ACT_READ: begin
                rsp = '0;
                if (r.read_column >= cols || r.read_row >= rows) begin
                    rsp.out_of_grid = 1'b1;
                end else begin
                    rsp.cell_x     = centered_coord(r.read_column, cols, m_cell_width);
                    rsp.cell_y     = centered_coord(r.read_row, rows, m_cell_height);
                    rsp.cell_depth = grid_depths[r.read_row * MAX_COLUMNS + r.read_column];
                end
                pending_reads.push_back(rsp);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_cell_response(t_rsp got);
        t_rsp want;
        if (pending_reads.size() == 0) begin
            report_mismatch("response with no read outstanding");
            return;
        end
        want = pending_reads.pop_front();
        if (got.cell_x !== want.cell_x)
            report_mismatch($sformatf("cell_x got %h want %h", got.cell_x, want.cell_x));
        if (got.cell_y !== want.cell_y)
            report_mismatch($sformatf("cell_y got %h want %h", got.cell_y, want.cell_y));
        if (got.cell_depth !== want.cell_depth)
            report_mismatch($sformatf("cell_depth got %h want %h",
                                      got.cell_depth, want.cell_depth));
        if (got.out_of_grid !== want.out_of_grid)
            report_mismatch($sformatf("out_of_grid got %b want %b",
                                      got.out_of_grid, want.out_of_grid));
    endtask

    // sample side: request acceptance, prediction, response check, run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("point_cloud_depth_grid test failed");
            $finish;
        end else begin
            req_fire = i_req_valid && (o_req_ready === 1'b1);
            if (req_fire) begin
                predict_grid_request(i_req);
                last_was_clear = (i_req.action == ACT_CLEAR);
                taken_total++;
            end
            if (i_rsp_ready && o_rsp_valid === 1'b1) check_cell_response(o_rsp);
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_req_valid || req_fire) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_req       <= req_backlog.pop_front();
                i_req_valid <= 1'b1;
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // response acceptor, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (phase_id == PRESSURE_PHASE && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_GRID_COLUMNS:        m_grid_columns    = val[SIZE_W-1:0];
            CFG_GRID_ROWS:           m_grid_rows       = val[SIZE_W-1:0];
            CFG_CELL_WIDTH:          m_cell_width      = val;
            CFG_CELL_HEIGHT:         m_cell_height     = val;
            CFG_INVERSE_CELL_WIDTH:  m_inv_cell_width  = val;
            CFG_INVERSE_CELL_HEIGHT: m_inv_cell_height = val;
            CFG_FILL_DEPTH:          m_fill_depth      = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [DATA_W-1:0] cols, logic [DATA_W-1:0] rows,
                                logic [DATA_W-1:0] cw, logic [DATA_W-1:0] ch,
                                logic [DATA_W-1:0] iw, logic [DATA_W-1:0] ih,
                                logic [DATA_W-1:0] fill);
        write_reg(CFG_GRID_COLUMNS, cols);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_CELL_WIDTH, cw);
        write_reg(CFG_CELL_HEIGHT, ch);
        write_reg(CFG_INVERSE_CELL_WIDTH, iw);
        write_reg(CFG_INVERSE_CELL_HEIGHT, ih);
        write_reg(CFG_FILL_DEPTH, fill);
    endtask

    task automatic queue_req(logic [1:0] act, logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                             logic [DATA_W-1:0] pz, int col, int row);
        t_req r;
        r.action      = act;
        r.point_x     = px;
        r.point_y     = py;
        r.point_z     = pz;
        r.read_column = READ_W'(col);
        r.read_row    = READ_W'(row);
        req_backlog.push_back(r);
        sent_total++;
    endtask

    // wait until every request is taken and answered; a trailing clear needs its sweep
    task automatic drain();
        while (taken_total != sent_total || pending_reads.size() != 0) @(posedge i_clk);
        repeat (last_was_clear ? SWEEP_CYCLES : SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // coordinate that mostly lands near the grid for the given inverse spacing
    function automatic logic [DATA_W-1:0] random_coord(int half, logic [DATA_W-1:0] inv);
        logic [63:0]       span;
        logic [DATA_W-1:0] mag;
        if ($urandom_range(9) == 0) return $urandom();
        span = ((64'(half) + 64'd2) << 32) / {32'd0, inv};
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        mag = $urandom_range(span[31:0]);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic random_phase(int count);
        int                cols;
        int                rows;
        int                pick;
        int                slot;
        int                reach_c;
        int                reach_r;
        longint            col;
        longint            row;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        int                recent_col [$];
        int                recent_row [$];
        cols    = grid_extent(m_grid_columns, MAX_COLUMNS);
        rows    = grid_extent(m_grid_rows, MAX_ROWS);
        reach_c = (cols + 1 > 255) ? 255 : cols + 1;
        reach_r = (rows + 1 > 255) ? 255 : rows + 1;
        queue_req(ACT_CLEAR, $urandom(), $urandom(), $urandom(),
                  $urandom_range(255), $urandom_range(255));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (i == count / 2) begin
                queue_req(ACT_CLEAR, $urandom(), $urandom(), $urandom(),
                          $urandom_range(255), $urandom_range(255));
            end else if (pick < 4) begin
                queue_req(ACT_UNUSED, $urandom(), $urandom(), $urandom(),
                          $urandom_range(255), $urandom_range(255));
            end else if (pick < 52) begin
                px  = random_coord(cols / 2, m_inv_cell_width);
                py  = random_coord(rows / 2, m_inv_cell_height);
                col = scaled_index(px, m_inv_cell_width) + cols / 2;
                row = scaled_index(py, m_inv_cell_height) + rows / 2;
                queue_req(ACT_ADD, px, py, $urandom(), $urandom_range(255),
                          $urandom_range(255));
                if (col >= 0 && col < cols && row >= 0 && row < rows) begin
                    recent_col.push_back(int'(col));
                    recent_row.push_back(int'(row));
                    if (recent_col.size() > RECENT_CELLS) begin
                        void'(recent_col.pop_front());
                        void'(recent_row.pop_front());
                    end
                    // read back what was just written, often straight away
                    if ($urandom_range(2) == 0)
                        queue_req(ACT_READ, $urandom(), $urandom(), $urandom(),
                                  int'(col), int'(row));
                end
            end else begin
                pick = $urandom_range(9);
                if (pick < 5 && recent_col.size() != 0) begin
                    slot = $urandom_range(recent_col.size() - 1);
                    queue_req(ACT_READ, $urandom(), $urandom(), $urandom(),
                              recent_col[slot], recent_row[slot]);
                end else if (pick < 9) begin
                    queue_req(ACT_READ, $urandom(), $urandom(), $urandom(),
                              $urandom_range(reach_c), $urandom_range(reach_r));
                end else begin
                    queue_req(ACT_READ, $urandom(), $urandom(), $urandom(),
                              $urandom_range(255), $urandom_range(255));
                end
            end
        end
    endtask

    initial begin
        m_grid_columns    = RESET_GRID_SIZE;
        m_grid_rows       = RESET_GRID_SIZE;
        m_cell_width      = RESET_SPACING;
        m_cell_height     = RESET_SPACING;
        m_inv_cell_width  = RESET_SPACING;
        m_inv_cell_height = RESET_SPACING;
        m_fill_depth      = RESET_FILL_DEPTH;
        for (int i = 0; i < STORE_CELLS; i++) grid_depths[i] = RESET_FILL_DEPTH;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, full 256x256 grid at unit spacing
        send_idle_pct = 20;
        rsp_idle_pct  = 47;
        set_geometry(256, 256, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0001_0000, RESET_FILL_DEPTH);
        queue_req(ACT_READ, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 255, 255);
        queue_req(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 128, 128);
        // -0.5 truncates toward zero, -1.0 lands one row down
        queue_req(ACT_ADD, 32'hFFFF_8000, 32'hFFFF_0000, 32'h8000_0000, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 128, 127);
        queue_req(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 0, 0);
        queue_req(ACT_ADD, 32'h8000_0000, 32'h0000_0000, 32'h0000_0002, 0, 0);
        queue_req(ACT_ADD, 32'hFF80_0000, 32'h007F_FFFF, 32'h1234_5678, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 0, 255);
        queue_req(ACT_ADD, 32'h007F_0000, 32'hFF7F_0000, 32'h0000_0003, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 255, 127);
        queue_req(ACT_UNUSED, $urandom(), $urandom(), $urandom(), 128, 128);
        queue_req(ACT_READ, 0, 0, 0, 128, 128);
        queue_req(ACT_CLEAR, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 128, 128);
        drain();

        // directed, small grid: reads past the configured edge
        set_geometry(16, 8, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0001_0000, 32'h0000_0000);
        queue_req(ACT_CLEAR, 0, 0, 0, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 15, 7);
        queue_req(ACT_READ, 0, 0, 0, 16, 0);
        queue_req(ACT_READ, 0, 0, 0, 0, 8);
        queue_req(ACT_READ, 0, 0, 0, 255, 255);
        queue_req(ACT_ADD, 32'h0007_FFFF, 32'hFFFC_0000, 32'hDEAD_BEEF, 0, 0);
        queue_req(ACT_READ, 0, 0, 0, 15, 0);
        drain();

        phase_id      = 1;
        send_idle_pct = 20;
        rsp_idle_pct  = 47;
        set_geometry(7, 5, 32'h0001_8000, 32'h0000_8000, 32'h0000_AAAB,
                     32'h0002_0000, $urandom());
        random_phase(330);
        drain();

        // clamped sizes and extreme spacings
        phase_id      = 2;
        send_idle_pct = 47;
        rsp_idle_pct  = 20;
        set_geometry(0, 511, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h8000_0000);
        random_phase(330);
        drain();

        // wide grid whose edge coordinates saturate; response side held off
        // through the opening clear and well into the reads that follow it
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        set_geometry(256, 3, 32'h0300_0000, 32'h0000_0001, 32'h0000_0100,
                     32'h0003_0000, 32'h7FFF_FFFF);
        phase_id = PRESSURE_PHASE;
        random_phase(330);
        drain();

        if (error_count == 0) begin
            $display("point_cloud_depth_grid test passed");
        end else begin
            $display("point_cloud_depth_grid test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pcdg_pkg.sv
rtl/core/pcdg_cfg.sv
rtl/core/pcdg_ctrl.sv
rtl/core/pcdg_dp.sv
rtl/core/point_cloud_depth_grid.sv
tb/point_cloud_depth_grid_tb.sv
